// ===== hw/rtl/replicated_log_apply_tables_top_defines.svh =====
// Assertion macros for the replicated log apply tables block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef REPLICATED_LOG_APPLY_TABLES_TOP_DEFINES_SVH
`define REPLICATED_LOG_APPLY_TABLES_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RLAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define RLAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rlat_pkg.sv =====
// Package for the replicated log apply tables block.
// Types, codes and defaults shared by the cells, the chain and the top level.
package rlat_pkg;

	localparam int MEMBER_SLOTS_DEF = 16;
	localparam int BLOCK_SLOTS_DEF  = 32;
	localparam int KERNEL_SLOTS_DEF = 16;
	localparam int PRINT_W          = 256;
	localparam int DATA_W           = PRINT_W + 32;
	localparam int LIDX_W           = 8;  // cell index, covers up to 256 slots
	localparam int LCNT_W           = 9;  // fill count, covers 0..256

	// entry modes
	localparam logic [3:0] MODE_ADD    = 4'd0;
	localparam logic [3:0] MODE_REMOVE = 4'd1;
	localparam logic [3:0] MODE_INTEG  = 4'd2;
	localparam logic [3:0] MODE_EV_LO  = 4'd3;
	localparam logic [3:0] MODE_EV_HI  = 4'd7;

	// outcome codes
	localparam logic [3:0] OC_RECORDED    = 4'd0;
	localparam logic [3:0] OC_ADDED       = 4'd1;
	localparam logic [3:0] OC_REACTIVATED = 4'd2;
	localparam logic [3:0] OC_MEMBER_FULL = 4'd3;
	localparam logic [3:0] OC_REMOVED     = 4'd4;
	localparam logic [3:0] OC_BLOCK_FULL  = 4'd5;
	localparam logic [3:0] OC_NOT_FOUND   = 4'd6;
	localparam logic [3:0] OC_UPDATED     = 4'd7;
	localparam logic [3:0] OC_INSERTED    = 4'd8;
	localparam logic [3:0] OC_TABLE_FULL  = 4'd9;
	localparam logic [3:0] OC_COUNTED     = 4'd10;
	localparam logic [3:0] OC_MALFORMED   = 4'd11;

	typedef struct packed {
		logic [3:0]  mode;
		logic [62:0] log_index;
		logic        well_formed;
		logic [31:0] ident;
		logic [31:0] caps;
		logic [63:0] payload_word0;
		logic [63:0] payload_word1;
		logic [63:0] payload_word2;
		logic [63:0] payload_word3;
	} rlat_in_t;

	typedef struct packed {
		logic [3:0]  outcome;
		logic [4:0]  slot;
		logic [4:0]  member_total;
		logic [4:0]  integrity_total;
		logic [5:0]  blocked_total;
		logic [31:0] counter_value;
	} rlat_out_t;

	// search token passed from cell to cell
	typedef struct packed {
		logic              vld;
		logic [31:0]       key;
		logic              hit;
		logic [LIDX_W-1:0] idx;
	} srch_t;

	// write command broadcast to all cells of a chain
	typedef struct packed {
		logic              en;
		logic [LIDX_W-1:0] idx;
		logic              set_id;
		logic              set_act;
		logic              set_data;
		logic              act;
		logic [31:0]       id;
		logic [DATA_W-1:0] data;
	} wr_t;

endpackage

// ===== hw/rtl/rlat_cell.sv =====
// One table entry of the apply tables: id, active flag and record data.
// Compares the passing search token and forwards it. Depends on rlat_pkg.
module rlat_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rlat_pkg::LCNT_W-1:0] used,
	input  rlat_pkg::srch_t           s_in,
	output rlat_pkg::srch_t           s_out,
	input  rlat_pkg::wr_t             wr
);

	logic [31:0]               id_q;
	logic                      act_q;
	logic [rlat_pkg::DATA_W-1:0] data_q;
	logic                      vld_q;
	logic [31:0]               key_q;
	logic                      hit_q;
	logic [rlat_pkg::LIDX_W-1:0] idx_q;
	logic                      sel;
	logic                      match;

	assign sel   = wr.en && (wr.idx == rlat_pkg::LIDX_W'(CELL_IDX));
	assign match = s_in.vld && !s_in.hit &&
		(rlat_pkg::LCNT_W'(CELL_IDX) < used) && (id_q == s_in.key);

	// entry storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (sel && wr.set_act) begin
			act_q <= wr.act;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && wr.set_id) begin
			id_q <= wr.id;
		end
		if (sel && wr.set_data) begin
			data_q <= wr.data;
		end
	end

	// token stage: first match marks the hit with this cell's index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= s_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= s_in.key;
		hit_q <= s_in.hit || match;
		idx_q <= match ? rlat_pkg::LIDX_W'(CELL_IDX) : s_in.idx;
	end

	assign s_out = '{vld: vld_q, key: key_q, hit: hit_q, idx: idx_q};

endmodule

// ===== hw/rtl/rlat_chain.sv =====
// Row of rlat_cell entries; a search token walks one cell per cycle.
// Depends on rlat_pkg and rlat_cell.
module rlat_chain #(
	parameter int SLOTS = rlat_pkg::MEMBER_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rlat_pkg::LCNT_W-1:0] used,
	input  rlat_pkg::srch_t           s_in,
	output rlat_pkg::srch_t           s_out,
	input  rlat_pkg::wr_t             wr
);

	rlat_pkg::srch_t link [SLOTS+1];

	assign link[0] = s_in;

	// cells in a row, token handed from each to the next
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		rlat_cell #(.CELL_IDX(g)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.used  (used),
			.s_in  (link[g]),
			.s_out (link[g+1]),
			.wr    (wr)
		);
	end

	assign s_out = link[SLOTS];

endmodule

// ===== hw/rtl/replicated_log_apply_tables_top.sv =====
// Top level of the replicated log apply tables block.
// Depends on rlat_pkg, rlat_chain and the assertion header.
//
// Usage:
//   Command channel: cmd is taken at a rising edge with start high and busy
//   low. One result follows each command on result, marked by result_valid
//   for exactly one cycle; the receiver cannot stall it.
// Sequence:
//   Add and remove entries walk the member cell row and integrity entries
//   walk the kernel row; the result strobe rises once the token leaves the
//   row and the apply state has run. Malformed, counted and other entries
//   skip the search. The length of the searched row sets how long it takes.
// Throughput:
//   One entry at a time; busy drops the cycle the result is shown, so the
//   next command may be taken while that result is on the ports.
// Reset:
//   arst_n clears all counts, counters, active flags and the last applied
//   index; the tables are empty and the block is ready at once.
`include "replicated_log_apply_tables_top_defines.svh"

module replicated_log_apply_tables_top #(
	parameter int MEMBER_SLOTS = rlat_pkg::MEMBER_SLOTS_DEF,
	parameter int BLOCK_SLOTS  = rlat_pkg::BLOCK_SLOTS_DEF,
	parameter int KERNEL_SLOTS = rlat_pkg::KERNEL_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rlat_pkg::rlat_in_t  cmd,
	output logic                result_valid,
	output rlat_pkg::rlat_out_t result
);

	localparam int BCNT_W = $clog2(BLOCK_SLOTS + 1);
	localparam int BIDX_W = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SRCH  = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t                      state_q;
	rlat_pkg::rlat_in_t          cmd_q;
	logic [62:0]                 last_index_q;
	logic [rlat_pkg::LCNT_W-1:0] member_used_q;
	logic [rlat_pkg::LCNT_W-1:0] kernel_used_q;
	logic [BCNT_W-1:0]           block_used_q;
	logic [31:0]                 ev_cnt_q [5];
	logic                        hit_q;
	logic [rlat_pkg::LIDX_W-1:0] hidx_q;
	logic [rlat_pkg::PRINT_W-1:0] block_mem [BLOCK_SLOTS];
	logic                        done_q;
	logic                        inj_q;
	rlat_pkg::rlat_out_t         res_q;

	rlat_pkg::srch_t s_inj, m_inj, k_inj, m_out, k_out;
	rlat_pkg::wr_t   m_wr, k_wr;
	logic            accept;
	logic            malformed;
	logic            is_member, is_kernel, is_event;
	logic [2:0]      ev_k;
	logic [31:0]     ev_new;
	logic [rlat_pkg::PRINT_W-1:0] print;
	rlat_pkg::rlat_out_t res_d;
	logic [rlat_pkg::LCNT_W-1:0] m_used_d, k_used_d;
	logic [BCNT_W-1:0]           b_used_d;
	logic            blk_we;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign malformed = (cmd_q.mode <= rlat_pkg::MODE_INTEG) && !cmd_q.well_formed;
	assign is_member = !malformed && ((cmd_q.mode == rlat_pkg::MODE_ADD) ||
		(cmd_q.mode == rlat_pkg::MODE_REMOVE));
	assign is_kernel = !malformed && (cmd_q.mode == rlat_pkg::MODE_INTEG);
	assign is_event  = (cmd_q.mode >= rlat_pkg::MODE_EV_LO) &&
		(cmd_q.mode <= rlat_pkg::MODE_EV_HI);
	assign ev_k      = 3'(cmd_q.mode - rlat_pkg::MODE_EV_LO);
	assign ev_new    = (ev_cnt_q[ev_k] == 32'hFFFF_FFFF) ? ev_cnt_q[ev_k]
		: ev_cnt_q[ev_k] + 32'd1;
	assign print     = {cmd_q.payload_word3, cmd_q.payload_word2,
		cmd_q.payload_word1, cmd_q.payload_word0};

	// search token key; valid is set per row below
	always_comb begin
		s_inj     = '0;
		s_inj.key = cmd_q.ident;
	end

	// token injected into the row that the entry searches, cycle after accept
	always_comb begin
		m_inj     = s_inj;
		k_inj     = s_inj;
		m_inj.vld = inj_q && is_member;
		k_inj.vld = inj_q && is_kernel;
	end

	// member and kernel cell rows
	rlat_chain #(.SLOTS(MEMBER_SLOTS)) u_members (
		.clk(clk), .arst_n(arst_n), .used(member_used_q),
		.s_in(m_inj), .s_out(m_out), .wr(m_wr)
	);

	rlat_chain #(.SLOTS(KERNEL_SLOTS)) u_kernels (
		.clk(clk), .arst_n(arst_n), .used(kernel_used_q),
		.s_in(k_inj), .s_out(k_out), .wr(k_wr)
	);

	// apply decision
	always_comb begin
		res_d    = '0;
		m_used_d = member_used_q;
		k_used_d = kernel_used_q;
		b_used_d = block_used_q;
		blk_we   = 1'b0;
		m_wr     = '0;
		k_wr     = '0;
		m_wr.data = rlat_pkg::DATA_W'(print);
		m_wr.id   = cmd_q.ident;
		m_wr.idx  = hidx_q;
		k_wr.data = {cmd_q.caps, print};
		k_wr.id   = cmd_q.ident;
		k_wr.idx  = hidx_q;
		if (malformed) begin
			res_d.outcome = rlat_pkg::OC_MALFORMED;
		end else if (cmd_q.mode == rlat_pkg::MODE_ADD) begin
			if (hit_q) begin
				m_wr.en       = 1'b1;
				m_wr.set_act  = 1'b1;
				m_wr.act      = 1'b1;
				res_d.outcome = rlat_pkg::OC_REACTIVATED;
				res_d.slot    = 5'(hidx_q);
			end else if (member_used_q >= rlat_pkg::LCNT_W'(MEMBER_SLOTS)) begin
				res_d.outcome = rlat_pkg::OC_MEMBER_FULL;
			end else begin
				m_wr.en       = 1'b1;
				m_wr.idx      = rlat_pkg::LIDX_W'(member_used_q);
				m_wr.set_act  = 1'b1;
				m_wr.act      = 1'b1;
				m_wr.set_id   = 1'b1;
				m_wr.set_data = 1'b1;
				m_used_d      = member_used_q + 1'b1;
				res_d.outcome = rlat_pkg::OC_ADDED;
				res_d.slot    = 5'(member_used_q);
			end
		end else if (cmd_q.mode == rlat_pkg::MODE_REMOVE) begin
			if (!hit_q) begin
				res_d.outcome = rlat_pkg::OC_NOT_FOUND;
			end else begin
				m_wr.en      = 1'b1;
				m_wr.set_act = 1'b1;
				m_wr.act     = 1'b0;
				res_d.slot   = 5'(hidx_q);
				if (block_used_q < BCNT_W'(BLOCK_SLOTS)) begin
					blk_we        = 1'b1;
					b_used_d      = block_used_q + 1'b1;
					res_d.outcome = rlat_pkg::OC_REMOVED;
				end else begin
					res_d.outcome = rlat_pkg::OC_BLOCK_FULL;
				end
			end
		end else if (cmd_q.mode == rlat_pkg::MODE_INTEG) begin
			if (hit_q) begin
				k_wr.en       = 1'b1;
				k_wr.set_data = 1'b1;
				res_d.outcome = rlat_pkg::OC_UPDATED;
				res_d.slot    = 5'(hidx_q);
			end else if (kernel_used_q >= rlat_pkg::LCNT_W'(KERNEL_SLOTS)) begin
				res_d.outcome = rlat_pkg::OC_TABLE_FULL;
			end else begin
				k_wr.en       = 1'b1;
				k_wr.idx      = rlat_pkg::LIDX_W'(kernel_used_q);
				k_wr.set_id   = 1'b1;
				k_wr.set_data = 1'b1;
				k_used_d      = kernel_used_q + 1'b1;
				res_d.outcome = rlat_pkg::OC_INSERTED;
				res_d.slot    = 5'(kernel_used_q);
			end
		end else if (is_event) begin
			res_d.outcome       = rlat_pkg::OC_COUNTED;
			res_d.counter_value = ev_new;
		end else begin
			res_d.outcome = rlat_pkg::OC_RECORDED;
		end
		if (state_q != ST_APPLY) begin
			m_wr.en = 1'b0;
			k_wr.en = 1'b0;
			blk_we  = 1'b0;
		end
		res_d.member_total    = 5'(m_used_d);
		res_d.integrity_total = 5'(k_used_d);
		res_d.blocked_total   = 6'(b_used_d);
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			inj_q         <= 1'b0;
			done_q        <= 1'b0;
			hit_q         <= 1'b0;
			member_used_q <= '0;
			kernel_used_q <= '0;
			block_used_q  <= '0;
			last_index_q  <= '0;
			for (int e = 0; e < 5; e++) begin
				ev_cnt_q[e] <= '0;
			end
		end else begin
			inj_q  <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						inj_q   <= 1'b1;
						hit_q   <= 1'b0;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (!inj_q && !is_member && !is_kernel) begin
						state_q <= ST_APPLY;
					end else if ((is_member && m_out.vld) || (is_kernel && k_out.vld)) begin
						hit_q   <= is_member ? m_out.hit : k_out.hit;
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					member_used_q <= m_used_d;
					kernel_used_q <= k_used_d;
					block_used_q  <= b_used_d;
					last_index_q  <= cmd_q.log_index;
					if (is_event) begin
						ev_cnt_q[ev_k] <= ev_new;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_SRCH) begin
			hidx_q <= is_member ? m_out.idx : k_out.idx;
		end
		if (state_q == ST_APPLY) begin
			res_q <= res_d;
		end
		if (blk_we) begin
			block_mem[block_used_q[BIDX_W-1:0]] <= print;
		end
	end

	assign result_valid = done_q;
	assign result       = res_q;

	`RLAT_ASSERT_NOW(a_strobe_idle, done_q, state_q == ST_IDLE, "result shown outside idle")
	`RLAT_ASSERT_NEXT(a_accept_busy, accept, busy, "not busy after accept")
	`RLAT_ASSERT_NEXT(a_strobe_single, done_q, !done_q, "result strobe longer than one cycle")
	`RLAT_ASSERT_NOW(a_member_cap, 1'b1,
		member_used_q <= rlat_pkg::LCNT_W'(MEMBER_SLOTS), "member count past capacity")

endmodule

// ===== bench/replicated_log_apply_tables_top_test.sv =====
// Testbench for the replicated log apply tables block: directed and random log entries.
// Depends on rlat_pkg and the top level; predicts every result with its own table model.
`timescale 1ns / 100ps

module replicated_log_apply_tables_top_test;

	localparam int MEMBERS = rlat_pkg::MEMBER_SLOTS_DEF;
	localparam int BLOCKS  = rlat_pkg::BLOCK_SLOTS_DEF;
	localparam int KERNELS = rlat_pkg::KERNEL_SLOTS_DEF;

	// Table model and queue of expected results
	class apply_scoreboard;
		logic [31:0]  mem_id [MEMBERS];
		bit           mem_act [MEMBERS];
		int           mem_cnt;
		int           blk_cnt;
		logic [31:0]  krn_id [KERNELS];
		int           krn_cnt;
		logic [31:0]  ev_cnt [5];
		rlat_pkg::rlat_out_t pending_results[$];
		int           errors;
		int           checked;
		int           oc_seen [16];

		function void clear();
			mem_cnt = 0;
			blk_cnt = 0;
			krn_cnt = 0;
			errors = 0;
			checked = 0;
			foreach (mem_id[i]) begin
				mem_id[i] = '0;
				mem_act[i] = 0;
			end
			foreach (krn_id[i]) krn_id[i] = '0;
			foreach (ev_cnt[i]) ev_cnt[i] = '0;
			foreach (oc_seen[i]) oc_seen[i] = 0;
		endfunction

		// apply one accepted transaction to the model, queue its result
		function void note_entry(rlat_pkg::rlat_in_t c);
			rlat_pkg::rlat_out_t r;
			int        hit_at;
			r = '0;
			hit_at = -1;
			if (c.mode <= rlat_pkg::MODE_INTEG && !c.well_formed) begin
				r.outcome = rlat_pkg::OC_MALFORMED;
			end else if (c.mode == rlat_pkg::MODE_ADD || c.mode == rlat_pkg::MODE_REMOVE) begin
				for (int i = 0; i < mem_cnt; i++)
					if (hit_at < 0 && mem_id[i] == c.ident) hit_at = i;
				if (c.mode == rlat_pkg::MODE_ADD) begin
					if (hit_at >= 0) begin
						mem_act[hit_at] = 1;
						r.outcome = rlat_pkg::OC_REACTIVATED;
						r.slot = hit_at[4:0];
					end else if (mem_cnt >= MEMBERS) begin
						r.outcome = rlat_pkg::OC_MEMBER_FULL;
					end else begin
						mem_id[mem_cnt] = c.ident;
						mem_act[mem_cnt] = 1;
						r.outcome = rlat_pkg::OC_ADDED;
						r.slot = mem_cnt[4:0];
						mem_cnt++;
					end
				end else if (hit_at < 0) begin
					r.outcome = rlat_pkg::OC_NOT_FOUND;
				end else begin
					mem_act[hit_at] = 0;
					r.slot = hit_at[4:0];
					if (blk_cnt < BLOCKS) begin
						blk_cnt++;
						r.outcome = rlat_pkg::OC_REMOVED;
					end else begin
						r.outcome = rlat_pkg::OC_BLOCK_FULL;
					end
				end
			end else if (c.mode == rlat_pkg::MODE_INTEG) begin
				for (int i = 0; i < krn_cnt; i++)
					if (hit_at < 0 && krn_id[i] == c.ident) hit_at = i;
				if (hit_at >= 0) begin
					r.outcome = rlat_pkg::OC_UPDATED;
					r.slot = hit_at[4:0];
				end else if (krn_cnt >= KERNELS) begin
					r.outcome = rlat_pkg::OC_TABLE_FULL;
				end else begin
					krn_id[krn_cnt] = c.ident;
					r.outcome = rlat_pkg::OC_INSERTED;
					r.slot = krn_cnt[4:0];
					krn_cnt++;
				end
			end else if (c.mode >= rlat_pkg::MODE_EV_LO && c.mode <= rlat_pkg::MODE_EV_HI) begin
				if (ev_cnt[c.mode - rlat_pkg::MODE_EV_LO] != 32'hFFFF_FFFF)
					ev_cnt[c.mode - rlat_pkg::MODE_EV_LO]++;
				r.counter_value = ev_cnt[c.mode - rlat_pkg::MODE_EV_LO];
				r.outcome = rlat_pkg::OC_COUNTED;
			end else begin
				r.outcome = rlat_pkg::OC_RECORDED;
			end
			r.member_total = mem_cnt[4:0];
			r.integrity_total = krn_cnt[4:0];
			r.blocked_total = blk_cnt[5:0];
			pending_results.push_back(r);
		endfunction

		function void check_result(rlat_pkg::rlat_out_t got);
			rlat_pkg::rlat_out_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			oc_seen[want.outcome]++;
			if (got.outcome !== want.outcome || got.slot !== want.slot ||
				got.member_total !== want.member_total ||
				got.integrity_total !== want.integrity_total ||
				got.blocked_total !== want.blocked_total ||
				got.counter_value !== want.counter_value) begin
				$display("%0t: mismatch expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	rlat_pkg::rlat_in_t  cmd;
	logic      result_valid;
	rlat_pkg::rlat_out_t result;

	apply_scoreboard sb;
	int              idle_pct;
	logic [31:0]     id_pool [8];
	logic [31:0]     kid_pool [8];

	replicated_log_apply_tables_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// note accepted commands and check results at each edge
	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_entry(cmd);
		if (arst_n && result_valid) sb.check_result(result);
	end

	// drive one entry, start held until taken; optional random gap before it
	task automatic send_entry(input rlat_pkg::rlat_in_t c);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	function automatic rlat_pkg::rlat_in_t random_entry(input logic [3:0] mode, input bit wf);
		rlat_pkg::rlat_in_t c;
		c.mode = mode;
		c.log_index = 63'({$urandom, $urandom});
		c.well_formed = wf;
		c.ident = $urandom_range(3) == 0 ? $urandom : id_pool[$urandom_range(7)];
		if (mode == rlat_pkg::MODE_INTEG)
			c.ident = $urandom_range(3) == 0 ? $urandom : kid_pool[$urandom_range(7)];
		c.caps = $urandom;
		c.payload_word0 = {$urandom, $urandom};
		c.payload_word1 = {$urandom, $urandom};
		c.payload_word2 = {$urandom, $urandom};
		c.payload_word3 = {$urandom, $urandom};
		return c;
	endfunction

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	initial begin
		rlat_pkg::rlat_in_t c;
		int       sel;
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		idle_pct = 0;
		foreach (id_pool[i]) id_pool[i] = $urandom;
		foreach (kid_pool[i]) kid_pool[i] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every mode, malformed and miss cases
		c = '0;
		send_entry(c);
		c = '1;
		c.mode = 4'd15;
		send_entry(c);
		c.mode = rlat_pkg::MODE_REMOVE;
		c.ident = 32'h0;
		send_entry(c);
		for (int m = 0; m <= 8; m++) begin
			c = random_entry(m[3:0], 1'b1);
			send_entry(c);
			c.well_formed = 1'b0;
			send_entry(c);
		end
		c = random_entry(rlat_pkg::MODE_ADD, 1'b1);
		c.ident = 32'hFFFF_FFFF;
		send_entry(c);
		c.mode = rlat_pkg::MODE_REMOVE;
		send_entry(c);
		c.mode = rlat_pkg::MODE_ADD;
		send_entry(c);
		c.mode = rlat_pkg::MODE_INTEG;
		c.ident = 32'h0;
		c.caps = '0;
		send_entry(c);
		send_entry(c);
		// sender waits for everything in flight
		drain();

		// random: three idling phases, biased toward table hits
		for (int n = 0; n < 1250; n++) begin
			idle_pct = n < 420 ? 9 : (n < 840 ? 58 : 0);
			sel = $urandom_range(99);
			if (sel < 30) c = random_entry(rlat_pkg::MODE_ADD, $urandom_range(9) != 0);
			else if (sel < 55) c = random_entry(rlat_pkg::MODE_REMOVE, $urandom_range(9) != 0);
			else if (sel < 75) c = random_entry(rlat_pkg::MODE_INTEG, $urandom_range(9) != 0);
			else if (sel < 95)
				c = random_entry(4'($urandom_range(rlat_pkg::MODE_EV_HI, rlat_pkg::MODE_EV_LO)),
					1'($urandom_range(1)));
			else c = random_entry(4'($urandom_range(15, 8)), 1'($urandom_range(1)));
			send_entry(c);
			if (n == 600) drain();
		end
		drain();

		$display("Applied %0d log entries; members %0d, kernels %0d, blocklisted %0d.",
			sb.checked, sb.mem_cnt, sb.krn_cnt, sb.blk_cnt);
		$display("Outcomes: full members %0d, full blocklist %0d, full kernels %0d.",
			sb.oc_seen[rlat_pkg::OC_MEMBER_FULL], sb.oc_seen[rlat_pkg::OC_BLOCK_FULL],
			sb.oc_seen[rlat_pkg::OC_TABLE_FULL]);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// run-time limit
	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== replicated_log_apply_tables_top.f =====
+incdir+hw/rtl
hw/rtl/rlat_pkg.sv
hw/rtl/rlat_cell.sv
hw/rtl/rlat_chain.sv
hw/rtl/replicated_log_apply_tables_top.sv
bench/replicated_log_apply_tables_top_test.sv
